/* hdl/range_gated_polar_conversion_top_defines.svh */
// Assertion macros shared by the range-gated polar conversion RTL.
`ifndef RANGE_GATED_POLAR_CONVERSION_TOP_DEFINES_SVH
`define RANGE_GATED_POLAR_CONVERSION_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define RGPC_CHECK(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define RGPC_CHECK_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* hdl/rgpc_pkg.sv */
// Types, constants and the arctangent table of the range-gated polar conversion.
`default_nettype none
package rgpc_pkg;

   // CORDIC datapath widths
   localparam int GUARD_BITS = 16;
   localparam int XY_W       = 36;
   localparam int Z_W        = 26;
   localparam int HALF_W     = 17;
   localparam int MAG_W      = 2 * HALF_W;
   localparam int GAIN_W     = 30;
   localparam int PROD_W     = HALF_W + GAIN_W;
   localparam int SUM_W      = MAG_W + GAIN_W + 1;
   localparam int MAG_SHIFT  = 30 + GUARD_BITS;
   localparam int ANGLE_FRAC = 8;
   localparam int ANGLE_W    = Z_W + 1;

   // Inverse CORDIC gain, round(2^30 / K)
   localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;
   localparam logic signed [15:0] ANGLE_LIMIT = 16'sd23040;

   // Result status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_LINK_FAIL  = 3'd1;
   localparam logic [2:0] ST_NOT_SEEN   = 3'd2;
   localparam logic [2:0] ST_TOO_NEAR   = 3'd3;
   localparam logic [2:0] ST_TOO_FAR    = 3'd4;
   localparam logic [2:0] ST_LAT_OUT    = 3'd5;

   // Register indexes
   localparam logic [1:0] CSR_CAMERA_OFFSET = 2'd0;
   localparam logic [1:0] CSR_MIN_FORWARD   = 2'd1;
   localparam logic [1:0] CSR_MAX_FORWARD   = 2'd2;
   localparam logic [1:0] CSR_MAX_LATERAL   = 2'd3;

   // Register reset values
   localparam logic signed [15:0] RST_CAMERA_OFFSET = 16'sd0;
   localparam logic signed [15:0] RST_MIN_FORWARD   = 16'sd0;
   localparam logic signed [15:0] RST_MAX_FORWARD   = 16'sd11200;
   localparam logic [14:0]        RST_MAX_LATERAL   = 15'd4800;

   // Fields carried alongside the CORDIC datapath
   typedef struct packed {
      logic [2:0]         status;
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic signed [15:0] robot_forward;
      logic signed [15:0] lateral;
   } meta_type;

   // One CORDIC cell's payload
   typedef struct packed {
      meta_type                meta;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [Z_W-1:0]   z;
   } stage_type;

   // atan(2^-i) in degrees, scaled by 2^16
   function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         0:       v = 26'sd2949120;
         1:       v = 26'sd1740967;
         2:       v = 26'sd919879;
         3:       v = 26'sd466945;
         4:       v = 26'sd234379;
         5:       v = 26'sd117304;
         6:       v = 26'sd58666;
         7:       v = 26'sd29335;
         8:       v = 26'sd14668;
         9:       v = 26'sd7334;
         10:      v = 26'sd3667;
         11:      v = 26'sd1833;
         12:      v = 26'sd917;
         13:      v = 26'sd458;
         14:      v = 26'sd229;
         15:      v = 26'sd115;
         16:      v = 26'sd57;
         17:      v = 26'sd29;
         18:      v = 26'sd14;
         19:      v = 26'sd7;
         20:      v = 26'sd4;
         21:      v = 26'sd2;
         22:      v = 26'sd1;
         default: v = 26'sd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

/* hdl/range_gated_polar_conversion_top.sv */
// Top level of the range-gated polar conversion: front cell, CORDIC cell chain, back end.
//
// Takes one target detection per transfer, adds the camera offset to the forward
// distance (saturating), gates it on the forward window and lateral limit, and
// returns heading atan2(lateral, forward) in 1/256 degree (0 if forward <= 0) and
// hypot distance in 1/16 mm. Rejected items return a nonzero status with all data
// fields zero. Throughput is one item per clock unless the result stalls. Items pass
// the front cell, one CORDIC rotation per cell and the back end (gain multiply split
// into two 17 x 30 bit halves). Every cell holds its item until the next one can take
// it, so a stalled result does not block upstream cells from filling. Configuration
// must be written only while no item is in flight; the block does not enforce this.
`default_nettype none
`include "range_gated_polar_conversion_top_defines.svh"
module range_gated_polar_conversion_top #(
   parameter int CORDIC_STAGES = 16,
   parameter int DIST_WIDTH    = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_en,
   input  wire logic [1:0]          csr_index,
   input  wire logic [15:0]         csr_wdata,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_link_ok,
   input  wire logic                req_target_seen,
   input  wire logic signed [15:0]  req_center_x,
   input  wire logic signed [15:0]  req_center_y,
   input  wire logic signed [15:0]  req_camera_forward,
   input  wire logic signed [15:0]  req_lateral_in,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [2:0]               rsp_status,
   output logic signed [15:0]       rsp_center_x_out,
   output logic signed [15:0]       rsp_center_y_out,
   output logic signed [15:0]       rsp_robot_forward,
   output logic signed [15:0]       rsp_lateral_out,
   output logic signed [15:0]       rsp_heading_angle,
   output logic [15:0]              rsp_straight_distance
);

   localparam int PIPE_DEPTH = CORDIC_STAGES + 4;
   localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);
   localparam int LIMIT_INT  = (DIST_WIDTH >= 16) ? 65535 : ((1 << DIST_WIDTH) - 1);

   rgpc_pkg::stage_type  chain_data  [CORDIC_STAGES+1];
   logic                 chain_valid [CORDIC_STAGES+1];
   logic                 chain_ready [CORDIC_STAGES+1];

   logic [OCC_W-1:0]     occ_ff;
   logic [OCC_W-1:0]     occ_in;
   logic                 req_xfer;
   logic                 rsp_xfer;

   rgpc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .link_ok        (req_link_ok),
      .target_seen    (req_target_seen),
      .center_x       (req_center_x),
      .center_y       (req_center_y),
      .camera_forward (req_camera_forward),
      .lateral_in     (req_lateral_in),
      .out_valid      (chain_valid[0]),
      .out_ready      (chain_ready[0]),
      .out_data       (chain_data[0])
   );

   // One rotation per cell
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      rgpc_cell #(.STAGE(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   rgpc_scale #(.DIST_WIDTH(DIST_WIDTH)) u_scale (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (chain_valid[CORDIC_STAGES]),
      .in_ready          (chain_ready[CORDIC_STAGES]),
      .in_data           (chain_data[CORDIC_STAGES]),
      .out_valid         (rsp_valid),
      .out_ready         (rsp_ready),
      .status            (rsp_status),
      .center_x_out      (rsp_center_x_out),
      .center_y_out      (rsp_center_y_out),
      .robot_forward     (rsp_robot_forward),
      .lateral_out       (rsp_lateral_out),
      .heading_angle     (rsp_heading_angle),
      .straight_distance (rsp_straight_distance)
   );

   // Track items in flight
   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      occ_in = occ_ff;
      if (req_xfer && !rsp_xfer) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (!req_xfer && rsp_xfer) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   `RGPC_CHECK_IMPL(a_reject_zero, rsp_valid && (rsp_status != rgpc_pkg::ST_OK), (rsp_center_x_out == 16'sd0) && (rsp_center_y_out == 16'sd0) && (rsp_robot_forward == 16'sd0) && (rsp_lateral_out == 16'sd0) && (rsp_heading_angle == 16'sd0) && (rsp_straight_distance == 16'd0), "rejected item carries data")
   `RGPC_CHECK_IMPL(a_angle_range, rsp_valid, (rsp_heading_angle <= rgpc_pkg::ANGLE_LIMIT) && (rsp_heading_angle >= -rgpc_pkg::ANGLE_LIMIT), "heading out of range")
   `RGPC_CHECK_IMPL(a_dist_limit, rsp_valid && (rsp_status == rgpc_pkg::ST_OK), rsp_straight_distance <= 16'(LIMIT_INT), "distance above limit")
   `RGPC_CHECK_IMPL(a_no_phantom, occ_ff == '0, !rsp_valid, "result with no item in flight")
   `RGPC_CHECK(a_occ_bound, occ_ff <= OCC_W'(PIPE_DEPTH), "more items in flight than cells")

endmodule
`default_nettype wire

/* hdl/rgpc_front.sv */
// Front cell: configuration registers, offset add, range gating and CORDIC seed.
`default_nettype none
module rgpc_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_en,
   input  wire logic [1:0]          csr_index,
   input  wire logic [15:0]         csr_wdata,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic                link_ok,
   input  wire logic                target_seen,
   input  wire logic signed [15:0]  center_x,
   input  wire logic signed [15:0]  center_y,
   input  wire logic signed [15:0]  camera_forward,
   input  wire logic signed [15:0]  lateral_in,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output rgpc_pkg::stage_type      out_data
);

   logic signed [15:0]   camera_offset_ff;
   logic signed [15:0]   min_forward_ff;
   logic signed [15:0]   max_forward_ff;
   logic [14:0]          max_lateral_ff;
   logic                 valid_ff;
   rgpc_pkg::stage_type  data_ff;
   rgpc_pkg::stage_type  data_in;

   logic signed [16:0]   fwd_sum;
   logic signed [15:0]   fwd_sat;
   logic signed [16:0]   fwd_ext;
   logic signed [16:0]   lat_ext;
   logic [16:0]          fwd_abs;
   logic [16:0]          lat_abs;
   logic [2:0]           status;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         camera_offset_ff <= rgpc_pkg::RST_CAMERA_OFFSET;
         min_forward_ff   <= rgpc_pkg::RST_MIN_FORWARD;
         max_forward_ff   <= rgpc_pkg::RST_MAX_FORWARD;
         max_lateral_ff   <= rgpc_pkg::RST_MAX_LATERAL;
      end else if (csr_write_en) begin
         case (csr_index)
            rgpc_pkg::CSR_CAMERA_OFFSET: camera_offset_ff <= csr_wdata;
            rgpc_pkg::CSR_MIN_FORWARD:   min_forward_ff   <= csr_wdata;
            rgpc_pkg::CSR_MAX_FORWARD:   max_forward_ff   <= csr_wdata;
            rgpc_pkg::CSR_MAX_LATERAL:   max_lateral_ff   <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // Add the camera offset and saturate to 16 bits
   always_comb begin
      fwd_sum = {camera_forward[15], camera_forward} + {camera_offset_ff[15], camera_offset_ff};
      if (fwd_sum[16] != fwd_sum[15]) begin
         fwd_sat = fwd_sum[16] ? 16'sh8000 : 16'sh7FFF;
      end else begin
         fwd_sat = fwd_sum[15:0];
      end
      fwd_ext = {fwd_sat[15], fwd_sat};
      lat_ext = {lateral_in[15], lateral_in};
      fwd_abs = fwd_sat[15] ? 17'(-fwd_ext) : 17'(fwd_ext);
      lat_abs = lateral_in[15] ? 17'(-lat_ext) : 17'(lat_ext);
   end

   // Gate on link, detection, forward window and lateral limit
   always_comb begin
      if (!link_ok) begin
         status = rgpc_pkg::ST_LINK_FAIL;
      end else if (!target_seen) begin
         status = rgpc_pkg::ST_NOT_SEEN;
      end else if (fwd_sat <= min_forward_ff) begin
         status = rgpc_pkg::ST_TOO_NEAR;
      end else if (fwd_sat > max_forward_ff) begin
         status = rgpc_pkg::ST_TOO_FAR;
      end else if (lat_abs > {2'b00, max_lateral_ff}) begin
         status = rgpc_pkg::ST_LAT_OUT;
      end else begin
         status = rgpc_pkg::ST_OK;
      end
   end

   // Seed the CORDIC: x from the absolute forward distance, y from lateral
   always_comb begin
      data_in.meta.status        = status;
      data_in.meta.center_x      = center_x;
      data_in.meta.center_y      = center_y;
      data_in.meta.robot_forward = fwd_sat;
      data_in.meta.lateral       = lateral_in;
      data_in.x = {{(rgpc_pkg::XY_W - 17 - rgpc_pkg::GUARD_BITS){1'b0}}, fwd_abs,
                   {rgpc_pkg::GUARD_BITS{1'b0}}};
      data_in.y = {{(rgpc_pkg::XY_W - 16 - rgpc_pkg::GUARD_BITS){lateral_in[15]}}, lateral_in,
                   {rgpc_pkg::GUARD_BITS{1'b0}}};
      data_in.z = '0;
   end

   assign in_ready = !valid_ff || out_ready;

   // Take a transfer whenever the cell is empty or draining
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

/* hdl/rgpc_cell.sv */
// One CORDIC vectoring cell: a single rotation with a fixed shift.
`default_nettype none
module rgpc_cell #(
   parameter int STAGE = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire rgpc_pkg::stage_type  in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output rgpc_pkg::stage_type       out_data
);

   logic                               valid_ff;
   rgpc_pkg::stage_type                data_ff;
   rgpc_pkg::stage_type                data_in;
   logic signed [rgpc_pkg::XY_W-1:0]   x_cur;
   logic signed [rgpc_pkg::XY_W-1:0]   y_cur;
   logic signed [rgpc_pkg::XY_W-1:0]   x_sh;
   logic signed [rgpc_pkg::XY_W-1:0]   y_sh;
   logic signed [rgpc_pkg::Z_W-1:0]    z_cur;

   // Rotate towards the x axis and accumulate the angle
   always_comb begin
      x_cur   = in_data.x;
      y_cur   = in_data.y;
      z_cur   = in_data.z;
      x_sh    = x_cur >>> STAGE;
      y_sh    = y_cur >>> STAGE;
      data_in = in_data;
      if (!y_cur[rgpc_pkg::XY_W-1]) begin
         data_in.x = x_cur + y_sh;
         data_in.y = y_cur - x_sh;
         data_in.z = z_cur + rgpc_pkg::atan_entry(STAGE);
      end else begin
         data_in.x = x_cur - y_sh;
         data_in.y = y_cur + x_sh;
         data_in.z = z_cur - rgpc_pkg::atan_entry(STAGE);
      end
   end

   assign in_ready = !valid_ff || out_ready;

   // Advance when the next cell can take the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

/* hdl/rgpc_scale.sv */
// Back end: angle rounding, split gain-correcting multiply and result register.
`default_nettype none
module rgpc_scale #(
   parameter int DIST_WIDTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire rgpc_pkg::stage_type  in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [2:0]                status,
   output logic signed [15:0]        center_x_out,
   output logic signed [15:0]        center_y_out,
   output logic signed [15:0]        robot_forward,
   output logic signed [15:0]        lateral_out,
   output logic signed [15:0]        heading_angle,
   output logic [15:0]               straight_distance
);

   localparam int LIMIT_INT = (DIST_WIDTH >= 16) ? 65535 : ((1 << DIST_WIDTH) - 1);
   localparam logic [15:0] DIST_LIMIT = 16'(LIMIT_INT);
   localparam int MAG_OUT_W = rgpc_pkg::SUM_W - rgpc_pkg::MAG_SHIFT;

   // Stage one: low partial product and angle
   logic                                 v1_ff;
   rgpc_pkg::meta_type                   meta1_ff;
   logic [rgpc_pkg::PROD_W-1:0]          plo1_ff;
   logic [rgpc_pkg::PROD_W-1:0]          plo1_in;
   logic [rgpc_pkg::HALF_W-1:0]          xhi1_ff;
   logic signed [15:0]                   ang1_ff;
   logic signed [15:0]                   ang1_in;
   logic [rgpc_pkg::MAG_W-1:0]           x_pos;
   logic signed [rgpc_pkg::ANGLE_W-1:0]  z_round;
   logic signed [rgpc_pkg::ANGLE_W-1:0]  ang_full;
   logic                                 ready1;

   // Stage two: high partial product
   logic                                 v2_ff;
   rgpc_pkg::meta_type                   meta2_ff;
   logic [rgpc_pkg::PROD_W-1:0]          plo2_ff;
   logic [rgpc_pkg::PROD_W-1:0]          phi2_ff;
   logic [rgpc_pkg::PROD_W-1:0]          phi2_in;
   logic signed [15:0]                   ang2_ff;
   logic                                 ready2;

   // Stage three: result register
   logic                                 v3_ff;
   logic [rgpc_pkg::SUM_W-1:0]           mag_sum;
   logic [MAG_OUT_W-1:0]                 mag_raw;
   logic [15:0]                          mag_sat;
   logic                                 ready3;
   logic [2:0]                           status_ff;
   logic signed [15:0]                   cx_ff;
   logic signed [15:0]                   cy_ff;
   logic signed [15:0]                   fwd_ff;
   logic signed [15:0]                   lat_ff;
   logic signed [15:0]                   ang_ff;
   logic [15:0]                          dist_ff;

   // Backpressure chain
   assign ready3   = !v3_ff || out_ready;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   // Clamp x, multiply its low half, round and limit the angle
   always_comb begin
      x_pos   = in_data.x[rgpc_pkg::XY_W-1] ? '0 : in_data.x[rgpc_pkg::MAG_W-1:0];
      plo1_in = rgpc_pkg::PROD_W'(x_pos[rgpc_pkg::HALF_W-1:0])
              * rgpc_pkg::PROD_W'(rgpc_pkg::INV_GAIN);
      z_round = {in_data.z[rgpc_pkg::Z_W-1], in_data.z}
              + rgpc_pkg::ANGLE_W'(1 << (rgpc_pkg::ANGLE_FRAC - 1));
      ang_full = z_round >>> rgpc_pkg::ANGLE_FRAC;
      if (in_data.meta.robot_forward <= 16'sd0) begin
         ang1_in = '0;
      end else if (ang_full > rgpc_pkg::ANGLE_W'(rgpc_pkg::ANGLE_LIMIT)) begin
         ang1_in = rgpc_pkg::ANGLE_LIMIT;
      end else if (ang_full < -rgpc_pkg::ANGLE_W'(rgpc_pkg::ANGLE_LIMIT)) begin
         ang1_in = -rgpc_pkg::ANGLE_LIMIT;
      end else begin
         ang1_in = ang_full[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ready1) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         meta1_ff <= in_data.meta;
         plo1_ff  <= plo1_in;
         xhi1_ff  <= x_pos[rgpc_pkg::MAG_W-1:rgpc_pkg::HALF_W];
         ang1_ff  <= ang1_in;
      end
   end

   // Multiply the high half of x
   assign phi2_in = rgpc_pkg::PROD_W'(xhi1_ff) * rgpc_pkg::PROD_W'(rgpc_pkg::INV_GAIN);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ready2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2 && v1_ff) begin
         meta2_ff <= meta1_ff;
         plo2_ff  <= plo1_ff;
         phi2_ff  <= phi2_in;
         ang2_ff  <= ang1_ff;
      end
   end

   // Combine partial products, round half up and saturate the distance
   always_comb begin
      mag_sum = (rgpc_pkg::SUM_W'(phi2_ff) << rgpc_pkg::HALF_W) + rgpc_pkg::SUM_W'(plo2_ff)
              + (rgpc_pkg::SUM_W'(1) << (rgpc_pkg::MAG_SHIFT - 1));
      mag_raw = mag_sum[rgpc_pkg::SUM_W-1:rgpc_pkg::MAG_SHIFT];
      mag_sat = (mag_raw > MAG_OUT_W'(DIST_LIMIT)) ? DIST_LIMIT : mag_raw[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (ready3) begin
         v3_ff <= v2_ff;
      end
   end

   // Drop data fields of rejected items
   always_ff @(posedge clock) begin
      if (ready3 && v2_ff) begin
         status_ff <= meta2_ff.status;
         if (meta2_ff.status == rgpc_pkg::ST_OK) begin
            cx_ff   <= meta2_ff.center_x;
            cy_ff   <= meta2_ff.center_y;
            fwd_ff  <= meta2_ff.robot_forward;
            lat_ff  <= meta2_ff.lateral;
            ang_ff  <= ang2_ff;
            dist_ff <= mag_sat;
         end else begin
            cx_ff   <= '0;
            cy_ff   <= '0;
            fwd_ff  <= '0;
            lat_ff  <= '0;
            ang_ff  <= '0;
            dist_ff <= '0;
         end
      end
   end

   assign out_valid         = v3_ff;
   assign status            = status_ff;
   assign center_x_out      = cx_ff;
   assign center_y_out      = cy_ff;
   assign robot_forward     = fwd_ff;
   assign lateral_out       = lat_ff;
   assign heading_angle     = ang_ff;
   assign straight_distance = dist_ff;

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the range-gated polar conversion top level.
`timescale 1ns / 1ps

module tb;

   localparam int CORDIC_STAGES = 16;
   localparam int DIST_WIDTH    = 16;
   localparam int LATENCY       = CORDIC_STAGES + 4;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 120;
   localparam longint unsigned INV_GAIN_Q30 = 64'd652032874;
   localparam int HEADING_CLAMP = 23040;

   // One detection as offered on the request side
   typedef struct packed {
      logic               link_ok;
      logic               target_seen;
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic signed [15:0] camera_forward;
      logic signed [15:0] lateral_in;
   } detection_type;

   // One converted result as seen on the response side
   typedef struct packed {
      logic [2:0]         status;
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic signed [15:0] robot_forward;
      logic signed [15:0] lateral;
      logic signed [15:0] heading_angle;
      logic [15:0]        straight_distance;
   } polar_type;

   // atan(2^-i) in degrees scaled by 2^16
   longint atan_q16 [0:23] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   logic clock;
   logic reset = 1'b1;

   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index    = 2'd0;
   logic [15:0] csr_wdata    = 16'd0;

   logic          req_valid = 1'b0;
   logic          req_ready;
   detection_type offered   = '0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_status;
   logic signed [15:0] rsp_center_x_out;
   logic signed [15:0] rsp_center_y_out;
   logic signed [15:0] rsp_robot_forward;
   logic signed [15:0] rsp_lateral_out;
   logic signed [15:0] rsp_heading_angle;
   logic [15:0]        rsp_straight_distance;

   // Register copy kept in step with every write
   logic signed [15:0] cfg_offset      = rgpc_pkg::RST_CAMERA_OFFSET;
   logic signed [15:0] cfg_min_forward = rgpc_pkg::RST_MIN_FORWARD;
   logic signed [15:0] cfg_max_forward = rgpc_pkg::RST_MAX_FORWARD;
   logic [14:0]        cfg_max_lateral = rgpc_pkg::RST_MAX_LATERAL;

   detection_type detections_pending [$];
   polar_type     polar_expected [$];
   polar_type     result_want;

   int req_idle_pct  = 38;
   int rsp_stall_pct = 38;
   int error_count   = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int input_stalls  = 0;
   int hold_left     = 0;
   int holds_done    = 0;
   int phases        = 0;
   int cycle_count   = 0;

   range_gated_polar_conversion_top #(
      .CORDIC_STAGES (CORDIC_STAGES),
      .DIST_WIDTH    (DIST_WIDTH)
   ) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_link_ok           (offered.link_ok),
      .req_target_seen       (offered.target_seen),
      .req_center_x          (offered.center_x),
      .req_center_y          (offered.center_y),
      .req_camera_forward    (offered.camera_forward),
      .req_lateral_in        (offered.lateral_in),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_center_x_out      (rsp_center_x_out),
      .rsp_center_y_out      (rsp_center_y_out),
      .rsp_robot_forward     (rsp_robot_forward),
      .rsp_lateral_out       (rsp_lateral_out),
      .rsp_heading_angle     (rsp_heading_angle),
      .rsp_straight_distance (rsp_straight_distance)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Gate one detection and convert it to heading and distance
   function automatic polar_type convert_detection(detection_type d);
      polar_type         r;
      int                fwd;
      int                afwd;
      int                lat;
      int                alat;
      int                i;
      longint            x;
      longint            y;
      longint            z;
      longint            xs;
      longint            ys;
      longint            ang;
      longint unsigned   mag;
      longint unsigned   dist_limit;
      r = '0;
      fwd = int'(d.camera_forward) + int'(cfg_offset);
      if (fwd > 32767) fwd = 32767;
      if (fwd < -32768) fwd = -32768;
      lat  = int'(d.lateral_in);
      alat = (lat < 0) ? -lat : lat;

      if (!d.link_ok) r.status = rgpc_pkg::ST_LINK_FAIL;
      else if (!d.target_seen) r.status = rgpc_pkg::ST_NOT_SEEN;
      else if (fwd <= int'(cfg_min_forward)) r.status = rgpc_pkg::ST_TOO_NEAR;
      else if (fwd > int'(cfg_max_forward)) r.status = rgpc_pkg::ST_TOO_FAR;
      else if (alat > int'(cfg_max_lateral)) r.status = rgpc_pkg::ST_LAT_OUT;
      else r.status = rgpc_pkg::ST_OK;
      if (r.status != rgpc_pkg::ST_OK) return r;

      // Vectoring rotations drive y towards zero
      afwd = (fwd < 0) ? -fwd : fwd;
      x = longint'(afwd) * 65536;
      y = longint'(lat) * 65536;
      z = 0;
      for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + atan_q16[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - atan_q16[i];
         end
      end

      // Round the angle to 1/256 degree; no heading without positive forward
      if (fwd > 0) begin
         ang = (z + 128) >>> 8;
         if (ang > HEADING_CLAMP) ang = HEADING_CLAMP;
         if (ang < -HEADING_CLAMP) ang = -HEADING_CLAMP;
      end else begin
         ang = 0;
      end

      // Remove the CORDIC gain, round half up, saturate
      mag = (x < 0) ? 64'd0 : x;
      mag = (mag * INV_GAIN_Q30 + (64'd1 << 45)) >> 46;
      dist_limit = (64'd1 << DIST_WIDTH) - 1;
      if (mag > dist_limit) mag = dist_limit;
      if (mag > 64'd65535) mag = 64'd65535;

      r.center_x          = d.center_x;
      r.center_y          = d.center_y;
      r.robot_forward     = 16'(fwd);
      r.lateral           = d.lateral_in;
      r.heading_angle     = 16'(ang);
      r.straight_distance = 16'(mag);
      return r;
   endfunction

   function automatic detection_type detection(bit link, bit seen, int cx, int cy,
                                               int fwd, int lat);
      detection_type d;
      d.link_ok        = link;
      d.target_seen    = seen;
      d.center_x       = 16'(cx);
      d.center_y       = 16'(cy);
      d.camera_forward = 16'(fwd);
      d.lateral_in     = 16'(lat);
      return d;
   endfunction

   // Mostly detections aimed at the current gate window, plus noise
   function automatic detection_type random_detection();
      detection_type d;
      int kind;
      int lo;
      int hi;
      int target;
      int cam;
      int lim;
      int lat;
      kind = $urandom_range(0, 99);
      d.link_ok     = 1'b1;
      d.target_seen = 1'b1;
      d.center_x    = 16'($urandom);
      d.center_y    = 16'($urandom);
      if (kind < 6) begin
         d.link_ok        = 1'($urandom_range(0, 1));
         d.target_seen    = 1'($urandom_range(0, 1));
         d.camera_forward = 16'($urandom);
         d.lateral_in     = 16'($urandom);
         return d;
      end
      if (kind < 10) begin
         d.link_ok     = 1'b0;
         d.target_seen = 1'($urandom_range(0, 1));
      end else if (kind < 14) begin
         d.target_seen = 1'b0;
      end

      // Pick a robot-frame forward, often on the window edges
      lo = int'(cfg_min_forward) + 1;
      hi = int'(cfg_max_forward);
      case ($urandom_range(0, 11))
         0:       target = lo - 1;
         1:       target = lo;
         2:       target = hi;
         3:       target = hi + 1;
         4:       target = int'($urandom_range(0, 65535)) - 32768;
         default: target = (hi >= lo) ? lo + int'($urandom_range(0, hi - lo)) : lo;
      endcase
      cam = target - int'(cfg_offset);
      if (cam > 32767) cam = 32767;
      if (cam < -32768) cam = -32768;
      d.camera_forward = 16'(cam);

      // Lateral inside the limit, on it, just past it, or anywhere
      lim = int'(cfg_max_lateral);
      case ($urandom_range(0, 9))
         0:       lat = lim + 1;
         1:       lat = lim;
         2:       lat = int'($urandom_range(0, 32768));
         default: lat = int'($urandom_range(0, lim));
      endcase
      if ($urandom_range(0, 1) == 1) lat = -lat;
      if (lat > 32767) lat = 32767;
      d.lateral_in = 16'(lat);
      return d;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want)
         report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                   results_seen, name, got, want));
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      case (idx)
         rgpc_pkg::CSR_CAMERA_OFFSET: cfg_offset      = value;
         rgpc_pkg::CSR_MIN_FORWARD:   cfg_min_forward = value;
         rgpc_pkg::CSR_MAX_FORWARD:   cfg_max_forward = value;
         rgpc_pkg::CSR_MAX_LATERAL:   cfg_max_lateral = value[14:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic load_config(input int offset, input int min_fwd, input int max_fwd,
                              input logic [15:0] lat_word);
      write_register(rgpc_pkg::CSR_CAMERA_OFFSET, 16'(offset));
      write_register(rgpc_pkg::CSR_MIN_FORWARD, 16'(min_fwd));
      write_register(rgpc_pkg::CSR_MAX_FORWARD, 16'(max_fwd));
      write_register(rgpc_pkg::CSR_MAX_LATERAL, lat_word);
      phases++;
   endtask

   task automatic push_random(input int count);
      repeat (count) detections_pending.push_back(random_detection());
   endtask

   // Hold until every queued detection is sent and every result is back
   task automatic wait_drained();
      while (detections_pending.size() != 0 || req_valid || polar_expected.size() != 0)
         @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // Request driver: predict on each transfer, then offer the next detection
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            polar_expected.push_back(convert_detection(offered));
            items_sent++;
         end
         if (req_valid && !req_ready) input_stalls++;
         if (!req_valid || req_ready) begin
            if (detections_pending.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
               req_valid <= 1'b1;
               offered   <= detections_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each transfer against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (polar_expected.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with none outstanding",
                                         results_seen));
            end else begin
               result_want = polar_expected.pop_front();
               check_field("status", rsp_status, result_want.status);
               check_field("center_x", rsp_center_x_out, result_want.center_x);
               check_field("center_y", rsp_center_y_out, result_want.center_y);
               check_field("robot_forward", rsp_robot_forward, result_want.robot_forward);
               check_field("lateral", rsp_lateral_out, result_want.lateral);
               check_field("heading", rsp_heading_angle, result_want.heading_angle);
               check_field("distance", rsp_straight_distance,
                           result_want.straight_distance);
            end
            results_seen++;
         end
         // Back-pressure: twice hold off long enough to fill the pipeline
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (holds_done < 2 && results_seen >= 200 + 600 * holds_done &&
                      detections_pending.size() > 100) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // Stimulus sequence
   initial begin
      int rnd_off;
      int rnd_min;
      int rnd_max;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: gate order, window edges and heading extremes
      detections_pending.push_back(detection(0, 1, 100, 200, 5000, 100));
      detections_pending.push_back(detection(0, 0, -1, -1, 5000, 100));
      detections_pending.push_back(detection(1, 0, 5, 5, 5000, 100));
      detections_pending.push_back(detection(1, 1, 32767, -32768, 0, 0));
      detections_pending.push_back(detection(1, 1, -32768, 32767, 1, 0));
      detections_pending.push_back(detection(1, 1, 0, 0, 11200, 0));
      detections_pending.push_back(detection(1, 1, 0, 0, 11201, 0));
      detections_pending.push_back(detection(1, 1, 1, 2, 3000, 4800));
      detections_pending.push_back(detection(1, 1, 3, 4, 3000, -4800));
      detections_pending.push_back(detection(1, 1, 0, 0, 3000, 4801));
      detections_pending.push_back(detection(1, 1, 0, 0, 3000, -32768));
      detections_pending.push_back(detection(1, 1, 0, 0, 1, 4800));
      detections_pending.push_back(detection(1, 1, 0, 0, 1, -4800));
      detections_pending.push_back(detection(1, 1, 0, 0, 4000, 4000));
      detections_pending.push_back(detection(1, 1, 0, 0, -32768, 32767));
      detections_pending.push_back(detection(1, 1, 0, 0, 32767, -1));
      push_random(220);
      phases++;
      wait_drained();

      // Widest window: negative forward accepted, negative saturation
      load_config(-800, -32768, 32767, 16'd32767);
      detections_pending.push_back(detection(1, 1, 0, 0, -100, 300));
      detections_pending.push_back(detection(1, 1, 0, 0, 800, -200));
      detections_pending.push_back(detection(1, 1, 0, 0, 32767, 32767));
      detections_pending.push_back(detection(1, 1, 0, 0, -32768, -32767));
      push_random(220);
      wait_drained();

      // Largest offset saturates forward; zero lateral limit
      load_config(32767, 100, 32767, 16'd0);
      detections_pending.push_back(detection(1, 1, 0, 0, 100, 0));
      push_random(200);
      wait_drained();

      // Most negative offset; bit 15 of the lateral word is dropped
      load_config(-32768, -32768, 0, 16'h8000 | 16'd1000);
      push_random(200);
      wait_drained();

      // Random settings with no idling on either side
      rnd_off = int'($urandom_range(0, 8000)) - 4000;
      rnd_min = int'($urandom_range(0, 8000)) - 4000;
      rnd_max = rnd_min + int'($urandom_range(1, 20000));
      load_config(rnd_off, rnd_min, rnd_max, 16'($urandom_range(0, 32767)));
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      push_random(240);
      wait_drained();
      req_idle_pct  = 38;
      rsp_stall_pct = 38;

      // Empty window: everything well formed is too near
      load_config(0, 32767, -32768, 16'd0);
      push_random(40);
      wait_drained();

      // Typical mounting offset
      load_config(1600, 160, 20000, 16'd8000);
      push_random(280);
      wait_drained();

      $display("covered %0d detections over %0d register settings, %0d results checked",
               items_sent, phases, results_seen);
      $display("%0d long receiver hold-offs, request side stalled for %0d cycles",
               holds_done, input_stalls);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", error_count);
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog
   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
         @(posedge clock);
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, polar_expected.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

/* range_gated_polar_conversion_top.f */
+incdir+hdl
hdl/rgpc_pkg.sv
hdl/rgpc_front.sv
hdl/rgpc_cell.sv
hdl/rgpc_scale.sv
hdl/range_gated_polar_conversion_top.sv
tb/tb.sv
